@@ rtl/core/gmcp_pkg.sv @@
// Shared state codes and types for the min-cut phase engine.
package gmcp_pkg;

    typedef logic [2:0] t_state;

    localparam t_state S_CLEAR = 3'd0;
    localparam t_state S_IDLE  = 3'd1;
    localparam t_state S_START = 3'd2;
    localparam t_state S_KEYS  = 3'd3;
    localparam t_state S_MERGE = 3'd4;
    localparam t_state S_ZERO  = 3'd5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

endpackage

@@ rtl/core/graph_min_cut_phases_core.sv @@
// Stoer-Wagner minimum-cut engine: weight matrix memory and phase sequencer.
// A load item is written into the matrix while idle; a run goes, per phase, through a row-sum scan,
// key passes, a merge of the last vertex into the previous one and zeroing of the merged vertex;
// each phase emits one item on o_strobe. Throughput is set by the single matrix memory walked
// one entry per cycle. Reset (synchronous, active low) starts a clearing pass over every matrix
// entry with busy high; results cannot be stalled by the receiver.
module graph_min_cut_phases_core
    import gmcp_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [3:0]  i_row,
    input  logic [3:0]  i_col,
    input  logic [15:0] i_weight,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    output logic        o_strobe,
    output logic [31:0] o_cut_weight,
    output logic [15:0] o_side_mask,
    output logic [3:0]  o_last_vertex,
    output logic        o_final_phase
);

    localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    // Only the canonical entry (low index, high index) of the symmetric matrix is stored.
    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
        f_addr = (a < b) ? {a, b} : {b, a};
    endfunction

    logic [15:0] wmask;
    assign wmask = 16'((33'd1 << WEIGHT_BITS) - 33'd1);

    // Matrix memory: one write port, two registered read ports
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rda, r_rdb;
    logic        we;
    logic [AW-1:0] wa, ra, rb;
    logic [31:0] wd;

    t_state r_state;
    logic [4:0]    r_vc;
    logic [IW-1:0] r_nm1;
    logic [IW-1:0] r_i, r_j, r_di, r_dj;
    logic          r_iss, r_dv;
    logic [31:0]   r_acc, r_best, r_cbest;
    logic          r_found, r_chave, r_kinit;
    logic [IW-1:0] r_start, r_kv, r_cand, r_prev, r_last;
    logic [CW-1:0] r_steps, r_alive_cnt;
    logic [MAX_VERTICES-1:0] r_alive, r_added;
    logic [31:0]   r_key   [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_group [MAX_VERTICES];
    logic [AW-1:0] r_clr;
    logic          r_strobe, r_final;
    logic [31:0]   r_cut;
    logic [15:0]   r_side;
    logic [3:0]    r_lastv;

    // Load decode
    logic          load_ok;
    logic [IW-1:0] row_v, col_v;
    logic [CW-1:0] n_run;

    assign busy  = (r_state != S_IDLE);
    assign row_v = IW'(i_row);
    assign col_v = IW'(i_col);
    assign load_ok = (32'(i_row) < MAX_VERTICES) && (32'(i_col) < MAX_VERTICES)
                     && (i_row != i_col);
    // Clamp the vertex count to the matrix size
    assign n_run = (32'(r_vc) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_vc);

    // Per-element datapath values
    logic [31:0]   row_sum, new_key, cut_sum;
    logic          cand_ok;
    logic [IW-1:0] st_next, pick;

    assign row_sum = ((r_dj == '0) ? 32'd0 : r_acc) + r_rda;
    assign cut_sum = ((r_dj == '0) ? 32'd0 : r_acc) + r_rdb;
    assign new_key = (r_kinit ? 32'd0 : r_key[r_dj]) + r_rda;
    assign cand_ok = r_alive[r_dj] && !r_added[r_dj] && (!r_chave || new_key >= r_cbest);
    assign pick    = cand_ok ? r_dj : r_cand;
    assign st_next = (r_alive[r_di] && (!r_found || row_sum > r_best)) ? r_di : r_start;

    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
            end
            S_IDLE: begin
                if (start && i_op == OP_LOAD && load_ok) begin
                    we = 1'b1;
                    wa = f_addr(row_v, col_v);
                    wd = 32'(i_weight & wmask);
                end
            end
            S_MERGE: begin
                if (r_dv && r_dj != r_prev && r_dj != r_last) begin
                    we = 1'b1;
                    wa = f_addr(r_prev, r_dj);
                    wd = r_rda + r_rdb;
                end
            end
            S_ZERO: begin
                we = 1'b1;
                wa = f_addr(r_last, r_j);
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_START: ra = f_addr(r_i, r_j);
            S_KEYS:  ra = f_addr(r_kv, r_j);
            default: ra = f_addr(r_prev, r_j);
        endcase
        rb = f_addr(r_last, r_j);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rda <= r_mem[ra];
        r_rdb <= r_mem[rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_vc        <= 5'd16;
            r_strobe    <= 1'b0;
            r_iss       <= 1'b0;
            r_dv        <= 1'b0;
            r_alive     <= '0;
            r_added     <= '0;
            r_found     <= 1'b0;
            r_chave     <= 1'b0;
            r_alive_cnt <= '0;
            r_steps     <= '0;
            r_i         <= '0;
            r_j         <= '0;
        end else begin
            // Raise the strobe for the cycle after the last cut element arrives
            r_strobe <= (r_state == S_MERGE) && r_dv && (r_dj == r_nm1);
            if (i_cfg_we) begin
                r_vc <= i_cfg_wdata;
            end
            // Delay the issue slot to line up with registered read data
            r_dv <= r_iss;
            r_dj <= r_j;
            r_di <= r_i;

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (start && i_op == OP_RUN) begin
                        r_nm1       <= IW'(n_run - 1'b1);
                        r_alive_cnt <= n_run;
                        for (int k = 0; k < MAX_VERTICES; k++) begin
                            r_alive[k] <= (CW'(k) < n_run);
                            r_group[k] <= MAX_VERTICES'(1) << k;
                        end
                        if (n_run >= CW'(2)) begin
                            r_state <= S_START;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_iss   <= 1'b1;
                            r_found <= 1'b0;
                        end
                    end
                end

                // Sum every row; keep the largest alive sum, lowest index on a tie
                S_START: begin
                    if (r_iss) begin
                        if (r_j == r_nm1) begin
                            r_j <= '0;
                            if (r_i == r_nm1) begin
                                r_iss <= 1'b0;
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        r_acc <= row_sum;
                        if (r_dj == r_nm1) begin
                            if (r_alive[r_di] && (!r_found || row_sum > r_best)) begin
                                r_best  <= row_sum;
                                r_start <= r_di;
                                r_found <= 1'b1;
                            end
                            if (r_di == r_nm1) begin
                                r_state <= S_KEYS;
                                r_kv    <= st_next;
                                r_kinit <= 1'b1;
                                r_added <= MAX_VERTICES'(1) << st_next;
                                r_prev  <= st_next;
                                r_last  <= st_next;
                                r_steps <= '0;
                                r_j     <= '0;
                                r_iss   <= 1'b1;
                                r_chave <= 1'b0;
                            end
                        end
                    end
                end

                // Add a row into the keys and pick the next vertex on the fly
                S_KEYS: begin
                    if (r_iss) begin
                        if (r_j == r_nm1) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        r_key[r_dj] <= new_key;
                        if (cand_ok) begin
                            r_cbest <= new_key;
                            r_cand  <= r_dj;
                        end
                        if (r_dj == r_nm1) begin
                            r_added[pick] <= 1'b1;
                            r_prev  <= r_last;
                            r_last  <= pick;
                            r_steps <= r_steps + 1'b1;
                            r_j     <= '0;
                            r_iss   <= 1'b1;
                            r_chave <= 1'b0;
                            r_kv    <= pick;
                            r_kinit <= 1'b0;
                            if ((r_steps + CW'(2)) == r_alive_cnt) begin
                                r_state <= S_MERGE;
                            end
                        end else if (cand_ok) begin
                            r_chave <= 1'b1;
                        end
                    end
                end

                // Fold the last row into the previous one and sum it as the cut
                S_MERGE: begin
                    if (r_iss) begin
                        if (r_j == r_nm1) begin
                            r_iss <= 1'b0;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        r_acc <= cut_sum;
                        if (r_dj == r_nm1) begin
                            r_cut         <= cut_sum;
                            r_side        <= 16'(r_group[r_last]);
                            r_lastv       <= 4'(r_last);
                            r_final       <= (r_alive_cnt == CW'(2));
                            r_group[r_prev] <= r_group[r_prev] | r_group[r_last];
                            r_alive[r_last] <= 1'b0;
                            r_alive_cnt   <= r_alive_cnt - 1'b1;
                            r_state       <= S_ZERO;
                            r_j           <= '0;
                        end
                    end
                end

                // Drop the merged vertex's row and column
                S_ZERO: begin
                    if (r_j == r_nm1) begin
                        r_j <= '0;
                        if (r_alive_cnt > CW'(1)) begin
                            r_state <= S_START;
                            r_i     <= '0;
                            r_iss   <= 1'b1;
                            r_found <= 1'b0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_cut_weight  = r_cut;
    assign o_side_mask   = r_side;
    assign o_last_vertex = r_lastv;
    assign o_final_phase = r_final;

endmodule

@@ bench/graph_min_cut_phases_checker.sv @@
// Checker for the min-cut phase engine: predicts cut results and compares them.
`timescale 1ns / 1ps
module graph_min_cut_phases_checker
    import gmcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_op,
    input  logic [3:0]  i_row,
    input  logic [3:0]  i_col,
    input  logic [15:0] i_weight,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        o_strobe,
    input  logic [31:0] o_cut_weight,
    input  logic [15:0] o_side_mask,
    input  logic [3:0]  o_last_vertex,
    input  logic        o_final_phase,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] cut_weight;
        logic [15:0] side_mask;
        logic [3:0]  last_vertex;
        logic        final_phase;
    } t_cut;

    logic [31:0] mat [16][16];
    logic [4:0]  vcount;
    t_cut        cut_queue [$];

    function automatic logic [31:0] row_sum(int v, int n);
        logic [31:0] acc;
        acc = 0;
        for (int j = 0; j < n; j++) acc += mat[v][j];
        return acc;
    endfunction

    // Run every phase on the mirror matrix and queue the cuts it yields.
    task automatic predict_run();
        int n, alive_cnt, st, prev, last, pick;
        logic [15:0] grp [16];
        logic [15:0] alive, added;
        logic [31:0] best, rs, key [16];
        t_cut c;
        n = (vcount > 16) ? 16 : vcount;
        alive = 0;
        for (int i = 0; i < n; i++) begin
            grp[i] = 16'(1) << i;
            alive[i] = 1'b1;
        end
        alive_cnt = n;
        while (alive_cnt > 1) begin
            st = 16;
            best = 0;
            for (int i = 0; i < n; i++) begin
                if (!alive[i]) continue;
                if (st == 16) st = i;
                rs = row_sum(i, n);
                if (rs > best) begin
                    best = rs;
                    st = i;
                end
            end
            added = 16'(1) << st;
            for (int i = 0; i < n; i++) key[i] = mat[i][st];
            prev = st;
            last = st;
            for (int j = 1; j < alive_cnt; j++) begin
                pick = 16;
                for (int i = 0; i < n; i++) begin
                    if (!alive[i] || added[i]) continue;
                    if (pick == 16 || key[i] >= key[pick]) pick = i;
                end
                if (pick == 16) break;
                added[pick] = 1'b1;
                for (int i = 0; i < n; i++) key[i] += mat[pick][i];
                prev = last;
                last = pick;
            end
            c.cut_weight  = row_sum(last, n);
            c.side_mask   = grp[last];
            c.last_vertex = 4'(last);
            grp[prev] |= grp[last];
            alive[last] = 1'b0;
            alive_cnt--;
            c.final_phase = (alive_cnt == 1);
            cut_queue.push_back(c);
            for (int j = 0; j < n; j++) begin
                if (j == prev) continue;
                mat[prev][j] += mat[last][j];
                mat[j][prev] += mat[last][j];
            end
            for (int i = 0; i < n; i++) begin
                mat[last][i] = 0;
                mat[i][last] = 0;
            end
        end
    endtask

    assign o_pending = cut_queue.size();

    always @(posedge i_clk) begin
        t_cut e;
        if (!i_rst_n) begin
            for (int r = 0; r < 16; r++)
                for (int k = 0; k < 16; k++) mat[r][k] = 0;
            vcount = 5'd16;
            cut_queue.delete();
            o_fail_count = 0;
        end else begin
            if (o_strobe) begin
                if (cut_queue.size() == 0) begin
                    $error("unexpected result: cut_weight %0d", o_cut_weight);
                    o_fail_count++;
                end else begin
                    e = cut_queue.pop_front();
                    if (o_cut_weight !== e.cut_weight) begin
                        $error("cut_weight expected %0d actual %0d", e.cut_weight, o_cut_weight);
                        o_fail_count++;
                    end
                    if (o_side_mask !== e.side_mask) begin
                        $error("side_mask expected %h actual %h", e.side_mask, o_side_mask);
                        o_fail_count++;
                    end
                    if (o_last_vertex !== e.last_vertex) begin
                        $error("last_vertex expected %0d actual %0d",
                               e.last_vertex, o_last_vertex);
                        o_fail_count++;
                    end
                    if (o_final_phase !== e.final_phase) begin
                        $error("final_phase expected %0d actual %0d",
                               e.final_phase, o_final_phase);
                        o_fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                if (i_op == OP_LOAD) begin
                    if (i_row != i_col) begin
                        mat[i_row][i_col] = {16'd0, i_weight};
                        mat[i_col][i_row] = {16'd0, i_weight};
                    end
                end else begin
                    predict_run();
                end
            end
            // A count written at this edge applies from the next item on
            if (i_cfg_we) vcount = i_cfg_wdata;
        end
    end

endmodule

@@ bench/graph_min_cut_phases_core_tb.sv @@
// Testbench top: drives load and run items and settings, and gives the verdict.
`timescale 1ns / 1ps
module graph_min_cut_phases_core_tb;
    import gmcp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = OP_LOAD;
    logic [3:0]  i_row = '0;
    logic [3:0]  i_col = '0;
    logic [15:0] i_weight = '0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        o_strobe;
    logic [31:0] o_cut_weight;
    logic [15:0] o_side_mask;
    logic [3:0]  o_last_vertex;
    logic        o_final_phase;
    int          fail_count;
    int          pending;
    int          idle_pct;
    int          cur_count;

    always #5 i_clk = ~i_clk;

    graph_min_cut_phases_core dut (.*);

    graph_min_cut_phases_checker checker_i (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // Present one item and hold it until the engine takes it; start stays high
    // afterwards so a following item can go back to back.
    task automatic send_item(logic op, logic [3:0] r, logic [3:0] c, logic [15:0] w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_op     <= op;
        i_row    <= r;
        i_col    <= c;
        i_weight <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start, then wait out every queued cut plus a little slack.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_count(logic [4:0] n);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_count = n;
    endtask

    // Load a random graph over the vertices in use; half of the weights are small.
    task automatic load_graph(int edges);
        logic [15:0] w;
        for (int k = 0; k < edges; k++) begin
            case ($urandom_range(3))
                0: w = $urandom;
                1: w = 16'hFFFF;
                default: w = $urandom_range(20);
            endcase
            send_item(OP_LOAD, 4'($urandom_range(cur_count - 1)),
                      4'($urandom_range(cur_count - 1)), w);
        end
    endtask

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        idle_pct = 0;
        cur_count = 16;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Directed: run on an all-zero graph at reset size, then extremes.
        send_item(OP_RUN, 4'd0, 4'd0, 16'd0);
        drain();
        set_count(5'd2);
        send_item(OP_LOAD, 4'd0, 4'd1, 16'hFFFF);
        send_item(OP_LOAD, 4'd3, 4'd3, 16'h1234);   // diagonal, ignored
        send_item(OP_LOAD, 4'd15, 4'd14, 16'hAAAA); // outside count, kept
        send_item(OP_RUN, 4'hF, 4'hF, 16'hFFFF);
        drain();
        set_count(5'd16);
        for (int v = 0; v < 15; v++) send_item(OP_LOAD, 4'(v), 4'(v + 1), 16'hFFFF);
        send_item(OP_LOAD, 4'd15, 4'd0, 16'h5555);
        send_item(OP_RUN, 4'd0, 4'd0, 16'd0);
        drain();
        set_count(5'd4);   // equal weights exercise both tie rules
        send_item(OP_LOAD, 4'd0, 4'd2, 16'd7);
        send_item(OP_LOAD, 4'd1, 4'd3, 16'd7);
        send_item(OP_RUN, 4'd0, 4'd0, 16'd0);
        drain();
        set_count(5'd1);   // below minimum, no cut expected
        send_item(OP_RUN, 4'd0, 4'd0, 16'd0);
        start <= 1'b0;
        repeat (400) @(posedge i_clk);
        drain();
        set_count(5'd31);  // above maximum, clipped
        send_item(OP_RUN, 4'd0, 4'd0, 16'd0);
        drain();

        // Random phases: cycle through idling levels and vertex counts.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 70;
                default: idle_pct = 21;
            endcase
            set_count((ph == 11) ? 5'd16 : 5'($urandom_range(2, 8)));
            load_graph(20);
            send_item(OP_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
            if (ph % 2 == 0) drain();
            load_graph(3);
            send_item(OP_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
            drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/gmcp_pkg.sv
rtl/core/graph_min_cut_phases_core.sv
bench/graph_min_cut_phases_checker.sv
bench/graph_min_cut_phases_core_tb.sv
